// ===== rtl/srrw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared types, constants and helpers of the selective-repeat receive window.
// ----------------------------------------------------------------------------
package srrw_pkg;

  localparam int unsigned WINDOW_SLOTS = 16;
  localparam int unsigned SLOT_BITS    = $clog2(WINDOW_SLOTS);
  localparam int unsigned HANDLE_BITS  = 8;
  localparam int unsigned HEADER_WORDS = 10;
  localparam int unsigned WORD_BITS    = 16;
  localparam int unsigned HDR_PAIRS    = (HEADER_WORDS + 1) / 2;
  localparam int unsigned SUM_BITS     = WORD_BITS + $clog2(HEADER_WORDS);

  localparam logic [WORD_BITS-1:0] CSUM_GOOD = 16'hffff;
  localparam int unsigned FLAG_SYN = 1;
  localparam int unsigned FLAG_FIN = 0;

  typedef enum logic [1:0] {
    KIND_SYNACK  = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_DELIVER = 2'd3
  } kind_e;

  typedef logic [HEADER_WORDS-1:0][WORD_BITS-1:0] hdr_words_t;

  typedef struct packed {
    logic [15:0] hdr_word0;
    logic [15:0] hdr_word1;
    logic [15:0] hdr_word2;
    logic [15:0] hdr_word3;
    logic [15:0] hdr_word4;
    logic [15:0] hdr_word5;
    logic [15:0] hdr_word6;
    logic [15:0] hdr_word7;
    logic [15:0] hdr_word8;
    logic [15:0] hdr_word9;
    logic [7:0]  body_handle;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] ack_number;
    logic        fin_flag;
    logic [7:0]  handle_out;
    logic [7:0]  body_offset;
    logic [15:0] body_length;
    logic        last;
  } out_t;

  // One stored packet of a window slot
  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [7:0]             name_len;
    logic [15:0]            body_len;
    logic                   fin;
  } slot_t;

  function automatic logic [SLOT_BITS-1:0] slot_add(input logic [SLOT_BITS-1:0] a,
                                                    input logic [SLOT_BITS-1:0] b);
    logic [SLOT_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (SLOT_BITS+1)'(WINDOW_SLOTS)) begin
      sum = sum - (SLOT_BITS+1)'(WINDOW_SLOTS);
    end
    return sum[SLOT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/srrw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_if
// Valid/ready channels for packet headers in and replies/deliveries out.
// ----------------------------------------------------------------------------
interface srrw_in_if;
  import srrw_pkg::*;
  logic valid;
  logic ready;
  in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface srrw_out_if;
  import srrw_pkg::*;
  logic valid;
  logic ready;
  out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/srrw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module srrw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/srrw_csum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_csum
// Header checksum: registered word sum, then end-around carry fold.
// ----------------------------------------------------------------------------
module srrw_csum (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  srrw_pkg::hdr_words_t words_i,
  output logic                 ok_o
);
  import srrw_pkg::*;

  logic [WORD_BITS:0]    pair_sum [HDR_PAIRS];
  logic [SUM_BITS-1:0]   total;
  logic [SUM_BITS-1:0]   sum_q;
  logic [WORD_BITS:0]    fold1;
  logic [WORD_BITS-1:0]  fold2;

  always_comb begin
    for (int i = 0; i < int'(HDR_PAIRS); i++) begin
      if (2 * i + 1 < int'(HEADER_WORDS)) begin
        pair_sum[i] = {1'b0, words_i[2*i]} + {1'b0, words_i[2*i+1]};
      end else begin
        pair_sum[i] = {1'b0, words_i[2*i]};
      end
    end
    total = '0;
    for (int i = 0; i < int'(HDR_PAIRS); i++) begin
      total = total + SUM_BITS'(pair_sum[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q <= total;
    end
  end

  // A zero sum folds to zero and fails, matching the all-zero header rule
  assign fold1 = {1'b0, sum_q[WORD_BITS-1:0]} + (WORD_BITS+1)'(sum_q[SUM_BITS-1:WORD_BITS]);
  assign fold2 = fold1[WORD_BITS-1:0] + WORD_BITS'(fold1[WORD_BITS]);
  assign ok_o  = (fold2 == CSUM_GOOD);

endmodule

// ===== rtl/selective_repeat_receive_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receive side of a selective-repeat transfer: checks headers, acknowledges,
// and releases stored packets in sequence order.
// ----------------------------------------------------------------------------
// A header is taken only while the block is idle. It passes through the
// checksum register and then evaluation, where it produces at most one
// reply; each in-order delivery that follows passes through a read state and
// a deliver state, set by the registered read port of the slot memory
// (address, then data). A header leads to up to 16 deliveries, and the
// output side can stall evaluation and every delivery. Results sit in an
// output register, so the next header is taken while the last result still
// waits. The slot memory needs no clearing: per-slot received bits live in
// flip-flops and only received slots are read.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  srrw_in_if.sink           in_i,
  srrw_out_if.source        out_o
);
  import srrw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_DELIV
  } state_e;

  state_e                  state_q, state_d;
  logic [15:0]             window_base_q, window_base_d;
  logic [SLOT_BITS-1:0]    base_slot_q, base_slot_d;
  logic [15:0]             last_ack_q, last_ack_d;
  logic [WINDOW_SLOTS-1:0] rcvd_q, rcvd_d;
  logic                    out_valid_q, out_valid_d;
  out_t                    out_data_q, out_data_d;

  logic [15:0]             seq_q;
  logic                    syn_q;
  logic                    fin_q;
  logic [7:0]              name_len_q;
  logic [15:0]             body_len_q;
  logic [HANDLE_BITS-1:0]  handle_q;

  hdr_words_t              words;
  logic                    in_xfer;
  logic                    hdr_ok;
  logic                    out_free;
  logic [15:0]             delta;
  logic                    in_win;
  logic                    left_win;
  logic [SLOT_BITS-1:0]    slot_w;
  logic [SLOT_BITS-1:0]    next_slot;
  logic                    more;

  logic                    ram_we;
  slot_t                   ram_wdata;
  slot_t                   ram_rdata;

  assign in_xfer = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign words[0] = in_i.payload.hdr_word0;
  assign words[1] = in_i.payload.hdr_word1;
  assign words[2] = in_i.payload.hdr_word2;
  assign words[3] = in_i.payload.hdr_word3;
  assign words[4] = in_i.payload.hdr_word4;
  assign words[5] = in_i.payload.hdr_word5;
  assign words[6] = in_i.payload.hdr_word6;
  assign words[7] = in_i.payload.hdr_word7;
  assign words[8] = in_i.payload.hdr_word8;
  assign words[9] = in_i.payload.hdr_word9;

  srrw_csum u_csum (
    .clk_i   (clk_i),
    .load_i  (in_xfer),
    .words_i (words),
    .ok_o    (hdr_ok)
  );

  assign ram_wdata.handle   = handle_q;
  assign ram_wdata.name_len = name_len_q;
  assign ram_wdata.body_len = body_len_q;
  assign ram_wdata.fin      = fin_q;

  // The read port always follows the window base slot
  srrw_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (WINDOW_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_w),
    .wdata_i (ram_wdata),
    .raddr_i (base_slot_q),
    .rdata_o (ram_rdata)
  );

  // Capture the header fields of the accepted transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      seq_q      <= in_i.payload.hdr_word2;
      syn_q      <= in_i.payload.hdr_word6[8 + FLAG_SYN];
      fin_q      <= in_i.payload.hdr_word6[8 + FLAG_FIN];
      name_len_q <= in_i.payload.hdr_word6[7:0];
      body_len_q <= in_i.payload.hdr_word8;
      handle_q   <= HANDLE_BITS'(in_i.payload.body_handle);
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_free  = !out_valid_q || out_o.ready;
  assign delta     = seq_q - window_base_q;
  assign in_win    = (delta < 16'(WINDOW_SLOTS));
  assign left_win  = delta[15];
  assign slot_w    = slot_add(base_slot_q, delta[SLOT_BITS-1:0]);
  assign next_slot = slot_add(base_slot_q, SLOT_BITS'(1));

  always_comb begin
    state_d       = state_q;
    window_base_d = window_base_q;
    base_slot_d   = base_slot_q;
    last_ack_d    = last_ack_q;
    rcvd_d        = rcvd_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_data_d    = out_data_q;
    ram_we        = 1'b0;
    more          = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        if (syn_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_data_d  = '0;
            out_data_d.last = 1'b1;
            if (hdr_ok) begin
              window_base_d = '0;
              base_slot_d   = '0;
              rcvd_d        = '0;
              last_ack_d    = seq_q;
              out_data_d.kind       = KIND_SYNACK;
              out_data_d.ack_number = seq_q;
            end else begin
              out_data_d.kind       = KIND_EMPTY;
              out_data_d.ack_number = last_ack_q;
            end
            state_d = S_IDLE;
          end
        end else if (!hdr_ok) begin
          state_d = S_IDLE;
        end else if (in_win) begin
          if (out_free) begin
            ram_we         = 1'b1;
            rcvd_d[slot_w] = 1'b1;
            last_ack_d     = seq_q;
            more           = rcvd_q[base_slot_q] || (slot_w == base_slot_q);
            out_valid_d    = 1'b1;
            out_data_d     = '0;
            out_data_d.kind       = KIND_ACK;
            out_data_d.ack_number = seq_q;
            out_data_d.fin_flag   = fin_q;
            out_data_d.last       = !more;
            state_d = more ? S_READ : S_IDLE;
          end
        end else if (left_win) begin
          if (out_free) begin
            last_ack_d  = seq_q;
            out_valid_d = 1'b1;
            out_data_d  = '0;
            out_data_d.kind       = KIND_ACK;
            out_data_d.ack_number = seq_q;
            out_data_d.fin_flag   = fin_q;
            out_data_d.last       = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          // Right of the window: drop
          state_d = S_IDLE;
        end
      end

      S_READ: begin
        state_d = S_DELIV;
      end

      S_DELIV: begin
        if (out_free) begin
          more                = rcvd_q[next_slot];
          rcvd_d[base_slot_q] = 1'b0;
          base_slot_d         = next_slot;
          window_base_d       = window_base_q + 16'd1;
          out_valid_d         = 1'b1;
          out_data_d.kind        = KIND_DELIVER;
          out_data_d.ack_number  = window_base_q;
          out_data_d.fin_flag    = ram_rdata.fin;
          out_data_d.handle_out  = 8'(ram_rdata.handle);
          out_data_d.body_offset = (window_base_q == '0) ? ram_rdata.name_len : 8'd0;
          out_data_d.body_length = ram_rdata.body_len;
          out_data_d.last        = !more;
          state_d = more ? S_READ : S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      window_base_q <= '0;
      base_slot_q   <= '0;
      last_ack_q    <= '0;
      rcvd_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      window_base_q <= window_base_d;
      base_slot_q   <= base_slot_d;
      last_ack_q    <= last_ack_d;
      rcvd_q        <= rcvd_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  a_syn_resets_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && syn_q && hdr_ok && out_free)
      |=> (rcvd_q == '0 && window_base_q == '0 && base_slot_q == '0))
    else $error("valid SYN did not reset the window");

  a_deliver_received : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DELIV || state_q == S_READ) |-> rcvd_q[base_slot_q])
    else $error("delivery from a slot that holds no packet");

  a_deliver_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DELIV && out_free)
      |=> (window_base_q == $past(window_base_q) + 16'd1 && !rcvd_q[$past(base_slot_q)]))
    else $error("window did not slide past a delivered slot");

endmodule
